[rtl/q24alu_pkg.sv]
// ----------------------------------------------------------------------------
// q24alu_pkg
// operation codes, item kinds and shared types of the fixed-point alu
// ----------------------------------------------------------------------------
package q24alu_pkg;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_MIN      = 4'd4;
  localparam logic [3:0] OP_MAX      = 4'd5;
  localparam logic [3:0] OP_INC      = 4'd6;
  localparam logic [3:0] OP_DEC      = 4'd7;
  localparam logic [3:0] OP_TO_INT   = 4'd8;
  localparam logic [3:0] OP_FROM_INT = 4'd9;

  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_MUL    = 2'd1;
  localparam logic [1:0] KIND_DIV    = 2'd2;

  localparam int MUL_CHUNK   = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic less;
    logic equal;
    logic greater;
    logic ovf;
    logic dz;
  } flags_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       neg;
    flags_t     flags;
  } ctrl_t;

endpackage

[rtl/q24alu_front.sv]
// ----------------------------------------------------------------------------
// q24alu_front
// decodes an item, finishes the simple operations and sets up
// multiply and divide for the back end
// ----------------------------------------------------------------------------
module q24alu_front import q24alu_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic [3:0]            req_type,
  input  logic signed [31:0]    operand_a,
  input  logic signed [31:0]    operand_b,
  output ctrl_t                 ctrl,
  output logic [DATA_WIDTH-1:0] res,
  output logic [DATA_WIDTH-1:0] ma,
  output logic [DATA_WIDTH-1:0] mb
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int WX = W + F + 1;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0]  a;
  logic signed [W-1:0]  b;
  logic signed [W-1:0]  r;
  logic signed [WX-1:0] wa;
  logic signed [WX-1:0] wb;
  logic signed [WX-1:0] wide;
  logic                 sat_en;
  logic                 ovf;
  logic                 dz;
  logic [1:0]           kind;

  assign a  = W'(operand_a);
  assign b  = W'(operand_b);
  assign wa = WX'(a);
  assign wb = WX'(b);

  assign ma = a[W-1] ? ~a + 1'b1 : a;
  assign mb = b[W-1] ? ~b + 1'b1 : b;

  always_comb begin
    wide   = '0;
    sat_en = 1'b0;
    ovf    = 1'b0;
    dz     = 1'b0;
    kind   = KIND_SIMPLE;
    r      = '0;
    case (req_type)
      OP_ADD: begin
        wide   = wa + wb;
        sat_en = 1'b1;
      end
      OP_SUB: begin
        wide   = wa - wb;
        sat_en = 1'b1;
      end
      OP_INC: begin
        wide   = wa + WX'(1);
        sat_en = 1'b1;
      end
      OP_DEC: begin
        wide   = wa - WX'(1);
        sat_en = 1'b1;
      end
      OP_FROM_INT: begin
        wide   = wa <<< F;
        sat_en = 1'b1;
      end
      OP_MUL: begin
        kind = KIND_MUL;
      end
      OP_DIV: begin
        if (b == '0) begin
          dz = 1'b1;
          r  = a[W-1] ? MINV : MAXV;
        end else begin
          kind = KIND_DIV;
        end
      end
      OP_MIN: begin
        r = (a < b) ? a : b;
      end
      OP_MAX: begin
        r = (a > b) ? a : b;
      end
      OP_TO_INT: begin
        r = a >>> F;
      end
      default: begin
        r = '0;
      end
    endcase
    if (sat_en) begin
      if (wide > WX'(MAXV)) begin
        r   = MAXV;
        ovf = 1'b1;
      end else if (wide < WX'(MINV)) begin
        r   = MINV;
        ovf = 1'b1;
      end else begin
        r = wide[W-1:0];
      end
    end
  end

  assign res                = r;
  assign ctrl.kind          = kind;
  assign ctrl.neg           = a[W-1] ^ b[W-1];
  assign ctrl.flags.less    = a < b;
  assign ctrl.flags.equal   = a == b;
  assign ctrl.flags.greater = a > b;
  assign ctrl.flags.ovf     = ovf;
  assign ctrl.flags.dz      = dz;

endmodule

[rtl/q24alu_queue.sv]
// ----------------------------------------------------------------------------
// q24alu_queue
// short fifo between the front end and the back end
// ----------------------------------------------------------------------------
module q24alu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/q24alu_back.sv]
// ----------------------------------------------------------------------------
// q24alu_back
// pipelined multiply and restoring divide, one quotient bit per stage,
// followed by saturation and the output register
// ----------------------------------------------------------------------------
module q24alu_back import q24alu_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  ctrl_t                 q_ctrl,
  input  logic [DATA_WIDTH-1:0] q_res,
  input  logic [DATA_WIDTH-1:0] q_ma,
  input  logic [DATA_WIDTH-1:0] q_mb,
  output logic                  o_valid,
  input  logic                  o_stall,
  output flags_t                o_flags,
  output logic [DATA_WIDTH-1:0] o_res
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NW   = W + F;
  localparam int PW   = 2 * W;
  localparam int C    = MUL_CHUNK;
  localparam int NMUL = (W + C - 1) / C;
  localparam int MBW  = NMUL * C;
  localparam int D    = W + F;

  localparam logic [PW-1:0] LIM_POS = PW'({1'b0, {(W-1){1'b1}}});
  localparam logic [PW-1:0] LIM_NEG = LIM_POS + 1'b1;
  localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    ctrl_t         ctrl;
    logic [W-1:0]  res;
    logic [W-1:0]  ma;
    logic [W-1:0]  mb;
    logic [W-1:0]  rem;
    logic [NW-1:0] num;
    logic [NW-1:0] quo;
    logic [PW-1:0] acc;
  } stage_t;

  stage_t        st [D];
  stage_t        src [D];
  stage_t        st_next [D];
  logic [PW-1:0] acc_next [D];
  logic [D-1:0]  st_valid;
  logic          adv;
  stage_t        last;
  logic [PW-1:0] mag;
  logic          over;
  logic [W-1:0]  res_next;
  flags_t        flags_next;

  assign adv   = !o_valid || !o_stall;
  assign q_pop = adv && q_valid;

  always_comb begin
    src[0].ctrl = q_ctrl;
    src[0].res  = q_res;
    src[0].ma   = q_ma;
    src[0].mb   = q_mb;
    src[0].rem  = '0;
    src[0].num  = {q_ma, {F{1'b0}}};
    src[0].quo  = '0;
    src[0].acc  = '0;
  end

  for (genvar k = 0; k < D; k++) begin : g_stage
    logic [W:0] t;
    logic       ge;

    if (k > 0) begin : g_link
      assign src[k] = st[k-1];
    end

    if (k < NMUL) begin : g_mul
      logic [MBW-1:0] mbx;
      logic [W+C-1:0] pp;
      assign mbx         = MBW'(src[k].mb);
      assign pp          = src[k].ma * mbx[k*C +: C];
      assign acc_next[k] = src[k].acc + (PW'(pp) << (k * C));
    end else begin : g_pass
      assign acc_next[k] = src[k].acc;
    end

    assign t  = {src[k].rem, src[k].num[NW-1]};
    assign ge = t >= {1'b0, src[k].mb};

    always_comb begin
      st_next[k]     = src[k];
      st_next[k].rem = ge ? W'(t - {1'b0, src[k].mb}) : t[W-1:0];
      st_next[k].quo = {src[k].quo[NW-2:0], ge};
      st_next[k].num = src[k].num << 1;
      st_next[k].acc = acc_next[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k] <= st_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= '0;
    end else if (adv) begin
      st_valid <= {st_valid[D-2:0], q_valid};
    end
  end

  assign last = st[D-1];

  always_comb begin
    mag        = (last.ctrl.kind == KIND_MUL) ? (last.acc >> F) : PW'(last.quo);
    over       = last.ctrl.neg ? (mag > LIM_NEG) : (mag > LIM_POS);
    flags_next = last.ctrl.flags;
    case (last.ctrl.kind)
      KIND_MUL, KIND_DIV: begin
        if (over) begin
          res_next       = last.ctrl.neg ? MINV : MAXV;
          flags_next.ovf = 1'b1;
        end else begin
          res_next = last.ctrl.neg ? ~mag[W-1:0] + 1'b1 : mag[W-1:0];
        end
      end
      default: begin
        res_next = last.res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= st_valid[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_res   <= res_next;
      o_flags <= flags_next;
    end
  end

endmodule

[rtl/q24_8_fixed_point_alu_core.sv]
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu_core
// signed fixed-point alu with saturation, top level
// ----------------------------------------------------------------------------
// Takes one item per cycle while in_stall is low and returns one result
// per cycle while out_stall is low. Every item passes the decoder, a
// four-entry fifo, DATA_WIDTH + FRAC_BITS back-end stages and the output
// register; stalls on the output fill the fifo first and only then raise
// in_stall. The depth is set by the divider, which produces one quotient
// bit per stage; the multiplier works on 16-bit slices of the magnitude of
// operand_b in the first stages. Operands are read as DATA_WIDTH-bit two's
// complement values, products and quotients truncate toward zero, and
// out-of-range results saturate with overflow set.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu_core import q24alu_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         req_type,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result,
  output logic               a_less,
  output logic               a_equal,
  output logic               a_greater,
  output logic               overflow,
  output logic               div_by_zero
);

  localparam int W  = DATA_WIDTH;
  localparam int CB = $bits(ctrl_t);
  localparam int EW = CB + 3 * W;

  ctrl_t               f_ctrl;
  logic [W-1:0]        f_res;
  logic [W-1:0]        f_ma;
  logic [W-1:0]        f_mb;
  logic [EW-1:0]       q_head;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  ctrl_t               q_ctrl;
  flags_t              o_flags;
  logic signed [W-1:0] o_res;

  q24alu_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .ctrl      (f_ctrl),
    .res       (f_res),
    .ma        (f_ma),
    .mb        (f_mb)
  );

  q24alu_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_data  ({f_ctrl, f_res, f_ma, f_mb}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign in_stall = q_full;
  assign q_ctrl   = q_head[EW-1 -: CB];

  q24alu_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_ctrl  (q_ctrl),
    .q_res   (q_head[3*W-1 -: W]),
    .q_ma    (q_head[2*W-1 -: W]),
    .q_mb    (q_head[W-1:0]),
    .o_valid (out_valid),
    .o_stall (out_stall),
    .o_flags (o_flags),
    .o_res   (o_res)
  );

  assign result      = 32'(o_res);
  assign a_less      = o_flags.less;
  assign a_equal     = o_flags.equal;
  assign a_greater   = o_flags.greater;
  assign overflow    = o_flags.ovf;
  assign div_by_zero = o_flags.dz;

endmodule
